[rtl/dcs_pkg.sv]
// Shared constants for the depth contrast stretch block.
// No dependencies; imported by the divider, the top level and the testbench.
`default_nettype none

package dcs_pkg;

  localparam int unsigned GRAY_W    = 8;
  localparam int unsigned QUOT_BITS = 8;
  localparam logic [GRAY_W-1:0] GRAY_MAX = 8'd255;
  localparam logic [GRAY_W-1:0] GRAY_MIN = 8'd0;

  // item kind codes
  localparam logic KIND_RANGE = 1'b0;
  localparam logic KIND_SCALE = 1'b1;

endpackage

`default_nettype wire

[rtl/dcs_range_track.sv]
// Running minimum/maximum of the range-finding pass samples.
// No dependencies.
`default_nettype none

module dcs_range_track #(
  parameter int unsigned SW = 16
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 upd_i,
  input  wire logic                 first_i,
  input  wire logic signed [SW-1:0] sample_i,
  output logic signed [SW-1:0]      min_o,
  output logic signed [SW-1:0]      max_o
);

  localparam logic signed [SW-1:0] SMAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] SMIN = {1'b1, {(SW-1){1'b0}}};

  logic signed [SW-1:0] min_q, min_d;
  logic signed [SW-1:0] max_q, max_d;

  always_comb begin
    min_d = min_q;
    max_d = max_q;
    if (upd_i) begin
      if (first_i) begin
        min_d = sample_i;
        max_d = sample_i;
      end else begin
        if (sample_i > max_q) max_d = sample_i;
        if (sample_i < min_q) min_d = sample_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q <= SMAX;
      max_q <= SMIN;
    end else begin
      min_q <= min_d;
      max_q <= max_d;
    end
  end

  assign min_o = min_q;
  assign max_o = max_q;

endmodule

`default_nettype wire

[rtl/dcs_div.sv]
// Restoring divider: one quotient bit per cycle shifted into a register.
// Depends on dcs_pkg (QUOT_BITS). Quotient must fit QUOT_BITS bits.
`default_nettype none

module dcs_div
  import dcs_pkg::*;
#(
  parameter int unsigned DW = 16
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  input  wire logic [DW+QUOT_BITS-1:0]   dividend_i,
  input  wire logic [DW-1:0]             divisor_i,
  output logic                           done_o,
  output logic [QUOT_BITS-1:0]           quot_o
);

  localparam int unsigned RW    = DW + QUOT_BITS;
  localparam int unsigned CNT_W = $clog2(QUOT_BITS);

  logic [RW-1:0]        rem_q;
  logic [RW-1:0]        den_q;
  logic [QUOT_BITS-1:0] quo_q;
  logic [CNT_W-1:0]     cnt_q;
  logic                 busy_q;
  logic                 done_q;
  logic [RW:0]          diff;
  logic                 fits;

  assign diff = {1'b0, rem_q} - {1'b0, den_q};
  assign fits = ~diff[RW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(QUOT_BITS - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  // divisor starts aligned to the top quotient bit and walks right
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= dividend_i;
      den_q <= {1'b0, divisor_i, {(QUOT_BITS-1){1'b0}}};
      quo_q <= '0;
    end else if (busy_q) begin
      if (fits) rem_q <= diff[RW-1:0];
      den_q <= {1'b0, den_q[RW-1:1]};
      quo_q <= {quo_q[QUOT_BITS-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

`default_nettype wire

[rtl/depth_contrast_stretch.sv]
// Depth contrast stretch: min/max tracking pass, then scaling to 8-bit gray.
// Range-pass beats: taken one per cycle while idle, no result.
// Scale-pass beats: offset, classify, 8-step restoring divider, divider done,
// output load (held while the output is full and stalled); the divider is
// skipped when clamped. The next beat is taken only once the block is idle again.
// Async active-low reset: min = largest positive, max = most negative.
`default_nettype none

module depth_contrast_stretch
  import dcs_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic                          kind_i,
  input  wire logic                          first_of_frame_i,
  input  wire logic signed [SAMPLE_BITS-1:0] depth_sample_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [GRAY_W-1:0]                  gray_level_o
);

  localparam int unsigned SW = SAMPLE_BITS;
  localparam int unsigned NW = SW + QUOT_BITS;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_CLASS,
    ST_DIV,
    ST_HOLD
  } state_e;

  state_e              state_q;
  logic                out_valid_q;
  logic [GRAY_W-1:0]   gray_q;
  logic [GRAY_W-1:0]   res_q;
  logic signed [SW-1:0] v_q;
  logic signed [SW:0]  num_q;
  logic signed [SW:0]  rng_q;

  logic                in_beat;
  logic                trk_upd;
  logic signed [SW-1:0] min_w, max_w;
  logic                div_start;
  logic                div_done;
  logic [QUOT_BITS-1:0] div_quot;
  logic [SW-1:0]       num_u;
  logic [NW-1:0]       dividend;
  logic                out_free;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_beat    = in_valid_i && in_ready_o;
  assign trk_upd    = in_beat && (kind_i == KIND_RANGE);
  assign out_free   = !out_valid_q || out_ready_i;

  dcs_range_track #(.SW(SW)) u_track (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .upd_i    (trk_upd),
    .first_i  (first_of_frame_i),
    .sample_i (depth_sample_i),
    .min_o    (min_w),
    .max_o    (max_w)
  );

  // dividend = num*255 = (num << 8) - num, num = v - min; only used when 0 < num < range
  assign num_u    = num_q[SW-1:0];
  assign dividend = {num_u, {QUOT_BITS{1'b0}}} - {{QUOT_BITS{1'b0}}, num_u};
  assign div_start = (state_q == ST_CLASS) && (rng_q > 0) && (num_q > 0)
                     && (num_q < rng_q);

  dcs_div #(.DW(SW)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend),
    .divisor_i  (rng_q[SW-1:0]),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      gray_q      <= '0;
    end else begin
      out_valid_q <= (out_valid_q && !out_ready_i) || ((state_q == ST_HOLD) && out_free);
      case (state_q)
        ST_IDLE: begin
          if (in_beat && (kind_i == KIND_SCALE)) state_q <= ST_PREP;
        end
        ST_PREP:  state_q <= ST_CLASS;
        ST_CLASS: state_q <= div_start ? ST_DIV : ST_HOLD;
        ST_DIV: begin
          if (div_done) state_q <= ST_HOLD;
        end
        ST_HOLD: begin
          if (out_free) begin
            gray_q  <= res_q;
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_beat) v_q <= depth_sample_i;
    if (state_q == ST_PREP) begin
      num_q <= {v_q[SW-1], v_q} - {min_w[SW-1], min_w};
      rng_q <= {max_w[SW-1], max_w} - {min_w[SW-1], min_w};
    end
    if (state_q == ST_CLASS) begin
      // empty range (no samples), flat range, at/below min, at/above max
      if (rng_q < 0)           res_q <= GRAY_MIN;
      else if (rng_q == 0)     res_q <= (num_q > 0) ? GRAY_MAX : GRAY_MIN;
      else if (num_q <= 0)     res_q <= GRAY_MIN;
      else if (num_q >= rng_q) res_q <= GRAY_MAX;
    end
    if ((state_q == ST_DIV) && div_done) res_q <= div_quot;
  end

  assign out_valid_o  = out_valid_q;
  assign gray_level_o = gray_q;

endmodule

`default_nettype wire

[tb/tb.sv]
// Testbench for depth_contrast_stretch: directed table, then random frames of
// range-finding and scaling beats, scored against an in-bench predictor.
// Depends on rtl/dcs_pkg.sv and rtl/depth_contrast_stretch.sv.
`timescale 1ns / 1ps

module tb
  import dcs_pkg::*;
();

  localparam int unsigned DEPTH_BITS   = 16;
  localparam int          DEPTH_TOP    = 32767;
  localparam int          DEPTH_BOTTOM = -32768;
  localparam int          ITEM_COUNT   = 450;
  localparam int          DRAIN_CYCLES = 40;
  localparam int          CYCLE_LIMIT  = 300000;
  localparam int          DIR_ROWS     = 25;

  typedef logic signed [DEPTH_BITS-1:0] depth_t;
  typedef bit bool_t;

  typedef struct packed {
    logic              kind;
    logic              first;
    depth_t            depth;
    logic              typed;
    logic [GRAY_W-1:0] gray;
  } stim_row_t;

  typedef enum logic [1:0] {
    RX_OPEN, RX_COIN, RX_ONE_IN_FOUR, RX_STALL_RUNS
  } rx_mode_e;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_ready_o;
  logic              kind_i;
  logic              first_of_frame_i;
  depth_t            depth_sample_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic [GRAY_W-1:0] gray_level_o;

  depth_t            track_min;
  depth_t            track_max;
  logic [GRAY_W-1:0] gray_expected [$];
  int                errors;
  int                cycles;
  int                beats_sent;
  int                burst_left;

  // expected gray is typed only where it reads off directly: nothing tracked,
  // zero range, clamps at or beyond the extremes
  stim_row_t dir_rows [DIR_ROWS] = '{
    '{KIND_SCALE, 1'b0, 16'sh0000, 1'b1, GRAY_MIN},
    '{KIND_SCALE, 1'b0, 16'sh7FFF, 1'b1, GRAY_MIN},
    '{KIND_SCALE, 1'b1, 16'sh8000, 1'b1, GRAY_MIN},
    '{KIND_RANGE, 1'b1, 16'sd100,  1'b0, GRAY_MIN},
    '{KIND_SCALE, 1'b0, 16'sd100,  1'b1, GRAY_MIN},
    '{KIND_SCALE, 1'b0, 16'sd101,  1'b1, GRAY_MAX},
    '{KIND_SCALE, 1'b0, 16'sd99,   1'b1, GRAY_MIN},
    '{KIND_RANGE, 1'b1, 16'sh8000, 1'b0, GRAY_MIN},
    '{KIND_RANGE, 1'b0, 16'sh7FFF, 1'b0, GRAY_MIN},
    '{KIND_SCALE, 1'b0, 16'sh8000, 1'b1, GRAY_MIN},
    '{KIND_SCALE, 1'b0, 16'sh7FFF, 1'b1, GRAY_MAX},
    '{KIND_SCALE, 1'b0, 16'sh0000, 1'b0, GRAY_MIN},
    '{KIND_SCALE, 1'b0, 16'shFFFF, 1'b0, GRAY_MIN},
    '{KIND_RANGE, 1'b1, 16'sh0000, 1'b0, GRAY_MIN},
    '{KIND_RANGE, 1'b0, 16'sd1000, 1'b0, GRAY_MIN},
    '{KIND_RANGE, 1'b0, 16'sd500,  1'b0, GRAY_MIN},
    '{KIND_SCALE, 1'b0, -16'sd5,   1'b1, GRAY_MIN},
    '{KIND_SCALE, 1'b0, 16'sd2000, 1'b1, GRAY_MAX},
    '{KIND_SCALE, 1'b0, 16'sd1000, 1'b1, GRAY_MAX},
    '{KIND_SCALE, 1'b1, 16'sd500,  1'b0, GRAY_MIN},
    '{KIND_SCALE, 1'b0, 16'sd1,    1'b0, GRAY_MIN},
    '{KIND_SCALE, 1'b0, 16'sd999,  1'b0, GRAY_MIN},
    '{KIND_RANGE, 1'b1, -16'sd7,   1'b0, GRAY_MIN},
    '{KIND_SCALE, 1'b0, -16'sd7,   1'b1, GRAY_MIN},
    '{KIND_SCALE, 1'b0, 16'sh7FFE, 1'b1, GRAY_MAX}
  };

  depth_contrast_stretch #(
    .SAMPLE_BITS(DEPTH_BITS)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .kind_i          (kind_i),
    .first_of_frame_i(first_of_frame_i),
    .depth_sample_i  (depth_sample_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .gray_level_o    (gray_level_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // gray level the block should give for a scaling beat, from the held range
  function automatic logic [GRAY_W-1:0] stretch_gray(depth_t v);
    int span;
    int offs;
    if (track_max < track_min) return GRAY_MIN;
    span = int'(track_max) - int'(track_min);
    offs = int'(v) - int'(track_min);
    if (span == 0) return (offs > 0) ? GRAY_MAX : GRAY_MIN;
    if (offs <= 0) return GRAY_MIN;
    if (offs >= span) return GRAY_MAX;
    return GRAY_W'((offs * int'(GRAY_MAX)) / span);
  endfunction

  function automatic depth_t clamp_depth(int x);
    if (x > DEPTH_TOP) return depth_t'(DEPTH_TOP);
    if (x < DEPTH_BOTTOM) return depth_t'(DEPTH_BOTTOM);
    return depth_t'(x);
  endfunction

  function automatic depth_t pick_between(int lo, int hi);
    return depth_t'(lo + int'($urandom_range(0, hi - lo)));
  endfunction

  task automatic report_mismatch(string note, logic [GRAY_W-1:0] want,
                                 logic [GRAY_W-1:0] got);
    errors++;
    $display("%0t: gray_level %s: expected %0d, got %0d", $time, note, want, got);
  endtask

  // one input beat; bursts of random length with random gaps in between
  task automatic send_beat(logic kind, logic first, depth_t depth, logic typed,
                           logic [GRAY_W-1:0] typed_gray);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 8));
      burst_left = ($urandom_range(0, 7) == 0) ? int'($urandom_range(60, 150))
                                               : int'($urandom_range(1, 24));
      if (gap > 0) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    burst_left--;
    @(negedge clk_i);
    in_valid_i       <= 1'b1;
    kind_i           <= kind;
    first_of_frame_i <= first;
    depth_sample_i   <= depth;
    do @(posedge clk_i); while (!in_ready_o);
    beats_sent++;
    if (kind == KIND_SCALE) begin
      gray_expected.push_back(typed ? typed_gray : stretch_gray(depth));
    end else if (first) begin
      track_min = depth;
      track_max = depth;
    end else begin
      if (depth > track_max) track_max = depth;
      if (depth < track_min) track_min = depth;
    end
  endtask

  // random frames: a range pass then a scaling pass, with some broken ones
  task automatic send_frame();
    int  lo;
    int  hi;
    int  n_range;
    int  n_scale;
    bool_t broken;
    depth_t v;
    broken  = ($urandom_range(0, 9) == 0);
    lo      = DEPTH_BOTTOM + int'($urandom_range(0, 65535));
    case ($urandom_range(0, 3))
      0:       hi = lo;
      1:       hi = lo + int'($urandom_range(1, 300));
      default: hi = lo + int'($urandom_range(1, 65535));
    endcase
    if (hi > DEPTH_TOP) hi = DEPTH_TOP;
    n_range = broken ? int'($urandom_range(0, 3)) : int'($urandom_range(1, 10));
    n_scale = $urandom_range(1, 10);
    for (int i = 0; i < n_range; i++) begin
      send_beat(KIND_RANGE, (i == 0) && !broken, pick_between(lo, hi), 1'b0, GRAY_MIN);
    end
    for (int i = 0; i < n_scale; i++) begin
      if ($urandom_range(0, 4) == 0) v = depth_t'($urandom_range(0, 65535));
      else v = clamp_depth(lo - 3 + int'($urandom_range(0, hi - lo + 6)));
      if (broken && $urandom_range(0, 3) == 0) begin
        send_beat(KIND_RANGE, 1'b0, v, 1'b0, GRAY_MIN);
      end else begin
        send_beat(KIND_SCALE, $urandom_range(0, 7) == 0, v, 1'b0, GRAY_MIN);
      end
    end
  endtask

  // result sink: changing stall pattern, with open stretches
  initial begin
    rx_mode_e mode;
    int       mode_left;
    int       stall_run;
    int       phase;
    out_ready_i = 1'b0;
    mode        = RX_OPEN;
    mode_left   = 0;
    stall_run   = 0;
    phase       = 0;
    forever begin
      @(negedge clk_i);
      if (mode_left == 0) begin
        mode      = rx_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(16, 96);
      end
      mode_left--;
      phase++;
      case (mode)
        RX_OPEN:        out_ready_i <= 1'b1;
        RX_COIN:        out_ready_i <= 1'($urandom_range(0, 1));
        RX_ONE_IN_FOUR: out_ready_i <= (phase % 4 == 0);
        default: begin
          if (stall_run > 0) begin
            out_ready_i <= 1'b0;
            stall_run--;
          end else begin
            out_ready_i <= 1'b1;
            if ($urandom_range(0, 3) == 0) stall_run = $urandom_range(1, 25);
          end
        end
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (gray_expected.size() == 0) begin
        report_mismatch("beat with nothing pending", 'x, gray_level_o);
      end else begin
        if (gray_level_o !== gray_expected[0]) begin
          report_mismatch("wrong", gray_expected[0], gray_level_o);
        end
        void'(gray_expected.pop_front());
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycles,
               gray_expected.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    rst_ni           = 1'b0;
    in_valid_i       = 1'b0;
    kind_i           = KIND_RANGE;
    first_of_frame_i = 1'b0;
    depth_sample_i   = '0;
    errors           = 0;
    cycles           = 0;
    beats_sent       = 0;
    burst_left       = 0;
    // predictor starts from the block's reset range: nothing tracked
    track_min        = depth_t'(DEPTH_TOP);
    track_max        = depth_t'(DEPTH_BOTTOM);
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) begin
      send_beat(dir_rows[i].kind, dir_rows[i].first, dir_rows[i].depth,
                dir_rows[i].typed, dir_rows[i].gray);
    end
    while (beats_sent < ITEM_COUNT) send_frame();

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (gray_expected.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[depth_contrast_stretch.f]
rtl/dcs_pkg.sv
rtl/dcs_range_track.sv
rtl/dcs_div.sv
rtl/depth_contrast_stretch.sv
tb/tb.sv
